// ===== hdl/dfs_pkg.sv =====
package dfs_pkg;

    localparam int VTX_W = 7;
    localparam logic [VTX_W-1:0] VERTEX_COUNT_RESET = 7'd64;

    localparam logic CMD_EDGE = 1'b0;
    localparam logic CMD_RUN  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EDGE_WR,
        ST_ROOT,
        ST_SCAN,
        ST_POP_WAIT,
        ST_EMIT_RD,
        ST_EMIT_LOAD,
        ST_EMIT_HOLD
    } state_t;

endpackage

// ===== hdl/dfs_topological_sort_core.sv =====
// dfs_topological_sort_core
//
// s_ channel: one transaction per command. s_tuser[0] is the command (0 adds an
// edge, 1 runs the sort); s_tdata carries from_vertex and to_vertex, 1-based.
// cfg channel: user writes vertex_count only while idle (unenforced); cfg_ready high.
// m_ channel: after a run, one transaction per vertex in finish-label order,
// 1-based vertex in m_tdata, m_tlast on the final one. A count of zero gives none.
//
// A valid edge is a read-modify-write of one adjacency row; an ignored edge
// goes straight back to idle. A run is accepted, then its search scans one
// adjacency column per cycle in the scan state, with an added step for each
// finished vertex, each root slot and each pop below the root. Results then
// go out one vertex at a time through read, load and hold states; hold waits
// for m_tready. One command is handled at a time; s_tready is high only
// between commands. A stalled result holds in the output register until
// taken. The run clears the matrix and visited flags via per-row valid bits.
// Reset (aresetn low, synchronous) empties the graph and sets vertex_count to 64.
module dfs_topological_sort_core #(
    parameter int MAX_VERTICES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // from_vertex[6:0], to_vertex[13:7], zero fill
    input  logic [0:0]  s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // vertex[6:0], zero fill
    output logic        m_tlast
);

    import dfs_pkg::*;

    localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int SW = VW + CW;

    state_t               state_reg, state_next;
    logic [VTX_W-1:0]     count_reg;
    logic [MAX_VERTICES-1:0] visited_reg, visited_next;
    logic [VW-1:0]        cur_v_reg, cur_v_next;
    logic [CW-1:0]        cur_j_reg, cur_j_next;
    logic [CW-1:0]        depth_reg, depth_next;
    logic [CW-1:0]        label_reg, label_next;
    logic [CW-1:0]        root_reg, root_next;
    logic [CW-1:0]        emit_k_reg, emit_k_next;
    logic [VW-1:0]        edge_from_reg, edge_from_next;
    logic [VW-1:0]        edge_to_reg, edge_to_next;
    logic                 out_valid_reg, out_valid_next;
    logic [VTX_W-1:0]     out_vertex_reg, out_vertex_next;
    logic                 out_last_reg, out_last_next;

    logic [CW-1:0]        n_eff;
    logic [VTX_W-1:0]     n_ext;
    logic [VTX_W-1:0]     s_from, s_to, from_m1, to_m1;
    logic                 edge_ok;
    logic [CW-1:0]        depth_m1, depth_m2, label_m1;
    logic [VW-1:0]        j_idx, r_idx;

    logic                    adj_clear, adj_wr_en, adj_rd_en;
    logic [VW-1:0]           adj_wr_addr, adj_rd_addr;
    logic [MAX_VERTICES-1:0] adj_wr_data, adj_rd_data;
    logic                    stk_wr_en, stk_rd_en;
    logic [VW-1:0]           stk_wr_addr, stk_rd_addr;
    logic [SW-1:0]           stk_wr_data, stk_rd_data;
    logic                    ord_wr_en, ord_rd_en;
    logic [VW-1:0]           ord_wr_addr, ord_rd_addr;
    logic [VW-1:0]           ord_wr_data, ord_rd_data;

    dfs_adj_ram #(
        .ROWS (MAX_VERTICES),
        .AW   (VW)
    ) u_adj (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (adj_clear),
        .wr_en   (adj_wr_en),
        .wr_addr (adj_wr_addr),
        .wr_data (adj_wr_data),
        .rd_en   (adj_rd_en),
        .rd_addr (adj_rd_addr),
        .rd_data (adj_rd_data)
    );

    dfs_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_VERTICES),
        .AW    (VW)
    ) u_stack (
        .aclk    (aclk),
        .wr_en   (stk_wr_en),
        .wr_addr (stk_wr_addr),
        .wr_data (stk_wr_data),
        .rd_en   (stk_rd_en),
        .rd_addr (stk_rd_addr),
        .rd_data (stk_rd_data)
    );

    dfs_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_VERTICES),
        .AW    (VW)
    ) u_order (
        .aclk    (aclk),
        .wr_en   (ord_wr_en),
        .wr_addr (ord_wr_addr),
        .wr_data (ord_wr_data),
        .rd_en   (ord_rd_en),
        .rd_addr (ord_rd_addr),
        .rd_data (ord_rd_data)
    );

    assign n_eff = (count_reg >= VTX_W'(MAX_VERTICES)) ? CW'(MAX_VERTICES)
                                                       : count_reg[CW-1:0];
    assign n_ext   = VTX_W'(n_eff);
    assign s_from  = s_tdata[6:0];
    assign s_to    = s_tdata[13:7];
    assign from_m1 = s_from - 7'd1;
    assign to_m1   = s_to - 7'd1;
    assign edge_ok = (s_from != '0) && (s_from <= n_ext) && (s_to != '0) && (s_to <= n_ext);

    assign depth_m1 = depth_reg - CW'(1);
    assign depth_m2 = depth_reg - CW'(2);
    assign label_m1 = label_reg - CW'(1);
    assign j_idx    = cur_j_reg[VW-1:0];
    assign r_idx    = root_reg[VW-1:0];

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {1'b0, out_vertex_reg};
    assign m_tlast   = out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= VERTEX_COUNT_RESET;
            visited_reg   <= '0;
            depth_reg     <= '0;
            label_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            visited_reg   <= visited_next;
            depth_reg     <= depth_next;
            label_reg     <= label_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cur_v_reg      <= cur_v_next;
        cur_j_reg      <= cur_j_next;
        root_reg       <= root_next;
        emit_k_reg     <= emit_k_next;
        edge_from_reg  <= edge_from_next;
        edge_to_reg    <= edge_to_next;
        out_vertex_reg <= out_vertex_next;
        out_last_reg   <= out_last_next;
    end

    always_comb begin
        state_next      = state_reg;
        visited_next    = visited_reg;
        cur_v_next      = cur_v_reg;
        cur_j_next      = cur_j_reg;
        depth_next      = depth_reg;
        label_next      = label_reg;
        root_next       = root_reg;
        emit_k_next     = emit_k_reg;
        edge_from_next  = edge_from_reg;
        edge_to_next    = edge_to_reg;
        out_valid_next  = out_valid_reg;
        out_vertex_next = out_vertex_reg;
        out_last_next   = out_last_reg;

        adj_clear   = 1'b0;
        adj_wr_en   = 1'b0;
        adj_wr_addr = edge_from_reg;
        adj_wr_data = adj_rd_data | (MAX_VERTICES'(1) << edge_to_reg);
        adj_rd_en   = 1'b0;
        adj_rd_addr = from_m1[VW-1:0];
        stk_wr_en   = 1'b0;
        stk_wr_addr = depth_m1[VW-1:0];
        stk_wr_data = {cur_j_reg + CW'(1), cur_v_reg};
        stk_rd_en   = 1'b0;
        stk_rd_addr = depth_m2[VW-1:0];
        ord_wr_en   = 1'b0;
        ord_wr_addr = label_m1[VW-1:0];
        ord_wr_data = cur_v_reg;
        ord_rd_en   = 1'b0;
        ord_rd_addr = emit_k_reg[VW-1:0];

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser[0] == CMD_RUN) begin
                        root_next  = '0;
                        label_next = n_eff;
                        depth_next = '0;
                        state_next = ST_ROOT;
                    end else if (edge_ok) begin
                        adj_rd_en      = 1'b1;
                        edge_from_next = from_m1[VW-1:0];
                        edge_to_next   = to_m1[VW-1:0];
                        state_next     = ST_EDGE_WR;
                    end
                end
            end
            ST_EDGE_WR: begin
                adj_wr_en  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_ROOT: begin
                if (root_reg == n_eff) begin
                    adj_clear    = 1'b1;
                    visited_next = '0;
                    emit_k_next  = '0;
                    state_next   = ST_EMIT_RD;
                end else if (visited_reg[r_idx]) begin
                    root_next = root_reg + CW'(1);
                end else begin
                    visited_next[r_idx] = 1'b1;
                    cur_v_next  = r_idx;
                    cur_j_next  = '0;
                    depth_next  = CW'(1);
                    adj_rd_en   = 1'b1;
                    adj_rd_addr = r_idx;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (cur_j_reg == n_eff) begin
                    // vertex finished: label it and pop
                    ord_wr_en  = 1'b1;
                    label_next = label_m1;
                    depth_next = depth_m1;
                    if (depth_reg == CW'(1)) begin
                        root_next  = root_reg + CW'(1);
                        state_next = ST_ROOT;
                    end else begin
                        stk_rd_en  = 1'b1;
                        state_next = ST_POP_WAIT;
                    end
                end else if (adj_rd_data[j_idx] && !visited_reg[j_idx]) begin
                    // spill current top, descend into neighbor
                    stk_wr_en           = 1'b1;
                    depth_next          = depth_reg + CW'(1);
                    visited_next[j_idx] = 1'b1;
                    cur_v_next          = j_idx;
                    cur_j_next          = '0;
                    adj_rd_en           = 1'b1;
                    adj_rd_addr         = j_idx;
                end else begin
                    cur_j_next = cur_j_reg + CW'(1);
                end
            end
            ST_POP_WAIT: begin
                cur_v_next  = stk_rd_data[VW-1:0];
                cur_j_next  = stk_rd_data[SW-1:VW];
                adj_rd_en   = 1'b1;
                adj_rd_addr = stk_rd_data[VW-1:0];
                state_next  = ST_SCAN;
            end
            ST_EMIT_RD: begin
                if (emit_k_reg == n_eff) begin
                    state_next = ST_IDLE;
                end else begin
                    ord_rd_en  = 1'b1;
                    state_next = ST_EMIT_LOAD;
                end
            end
            ST_EMIT_LOAD: begin
                out_vertex_next = VTX_W'(ord_rd_data) + 7'd1;
                out_last_next   = ((emit_k_reg + CW'(1)) == n_eff);
                out_valid_next  = 1'b1;
                emit_k_next     = emit_k_reg + CW'(1);
                state_next      = ST_EMIT_HOLD;
            end
            ST_EMIT_HOLD: begin
                if (m_tready) begin
                    out_valid_next = 1'b0;
                    state_next     = out_last_reg ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_no_accept_while_emitting: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input accepted while a result is pending");

    a_depth_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (depth_reg != '0 && depth_reg <= n_eff))
        else $error("stack depth out of range during search");

    a_visited_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (visited_reg == '0))
        else $error("visited flags not cleared after run");

    a_labels_used_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROOT && root_reg == n_eff) |-> (label_reg == '0))
        else $error("search ended with unassigned labels");

endmodule

// ===== hdl/dfs_ram.sv =====
module dfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/dfs_adj_ram.sv =====
module dfs_adj_ram #(
    parameter int ROWS = 64,
    parameter int AW   = 6
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            clear,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  logic [ROWS-1:0] wr_data,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr,
    output logic [ROWS-1:0] rd_data
);

    logic [ROWS-1:0] mem [ROWS];
    logic [ROWS-1:0] row_q_reg;
    logic [ROWS-1:0] valid_reg;
    logic            row_ok_reg;

    // row valid bits stand in for clearing the array
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (clear) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            row_q_reg  <= mem[rd_addr];
            row_ok_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = row_ok_reg ? row_q_reg : '0;

endmodule
